>>> sv/http_header_field_parser_assert.svh
// Assertion macros for the HTTP header field parser checker.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef HTTP_HEADER_FIELD_PARSER_ASSERT_SVH
`define HTTP_HEADER_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hhfp assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define HHFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hhfp assertion failed (next cycle)");

`endif

>>> sv/hhfp_pkg.sv
// Shared types and character constants for the HTTP header field parser.
// No dependencies.
package hhfp_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_NAME  = 3'd0,
        PH_SPACE = 3'd1,
        PH_VALUE = 3'd2,
        PH_AFTER = 3'd3,
        PH_DONE  = 3'd4,
        PH_ERROR = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_NAME      = 3'd0,
        K_NAME_END  = 3'd1,
        K_VALUE     = 3'd2,
        K_FIELD_END = 3'd3,
        K_DONE      = 3'd4,
        K_BODY      = 3'd5,
        K_INVALID   = 3'd6,
        K_SKIP      = 3'd7
    } t_kind;

    typedef struct packed {
        t_phase phase;
        logic   cr_after_field;
        logic   value_cr_held;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    // One decode step: next state plus one or two results.
    typedef struct packed {
        t_state  next;
        t_result r0;
        t_result r1;
        logic    two;
    } t_step;

    localparam t_state STATE_RESET = '{phase: PH_NAME, cr_after_field: 1'b0,
                                       value_cr_held: 1'b0};

endpackage

>>> sv/hhfp_decode.sv
// Per-byte decode of the header tagger: state and byte in, next state and results out.
// Depends on hhfp_pkg.
module hhfp_decode
    import hhfp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_step      o_step
);

    logic    w_name_char;
    t_result w_name_res;
    t_phase  w_name_phase;
    t_result w_val_res;
    t_phase  w_val_phase;
    logic    w_val_held;

    assign w_name_char = (i_byte >= 8'h30 && i_byte <= 8'h39) ||
                         (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                         (i_byte >= 8'h61 && i_byte <= 8'h7A) ||
                         (i_byte == CH_DASH) || (i_byte == CH_UNDER);

    // Name byte handling
    always_comb begin
        if (i_byte == CH_COLON) begin
            w_name_res   = '{kind: K_NAME_END, data: 8'h00};
            w_name_phase = PH_SPACE;
        end else if (w_name_char) begin
            w_name_res   = '{kind: K_NAME, data: i_byte};
            w_name_phase = PH_NAME;
        end else begin
            w_name_res   = '{kind: K_INVALID, data: 8'h00};
            w_name_phase = PH_ERROR;
        end
    end

    // Value byte handling with no CR pending
    always_comb begin
        w_val_held  = 1'b0;
        w_val_phase = PH_VALUE;
        if (i_byte == CH_CR) begin
            w_val_res  = '{kind: K_SKIP, data: 8'h00};
            w_val_held = 1'b1;
        end else if (i_byte == CH_LF) begin
            w_val_res   = '{kind: K_FIELD_END, data: 8'h00};
            w_val_phase = PH_AFTER;
        end else begin
            w_val_res = '{kind: K_VALUE, data: i_byte};
        end
    end

    always_comb begin
        o_step.next = i_state;
        o_step.r0   = '{kind: K_INVALID, data: 8'h00};
        o_step.r1   = '{kind: K_INVALID, data: 8'h00};
        o_step.two  = 1'b0;
        unique case (i_state.phase)
            PH_NAME: begin
                o_step.r0         = w_name_res;
                o_step.next.phase = w_name_phase;
            end
            PH_SPACE: begin
                if (i_byte == CH_SPACE) begin
                    o_step.r0 = '{kind: K_SKIP, data: 8'h00};
                end else begin
                    o_step.r0                 = w_val_res;
                    o_step.next.phase         = w_val_phase;
                    o_step.next.value_cr_held = w_val_held;
                end
            end
            PH_VALUE: begin
                if (i_state.value_cr_held && i_byte == CH_LF) begin
                    // CR LF: held CR dropped
                    o_step.r0                 = '{kind: K_FIELD_END, data: 8'h00};
                    o_step.next.phase         = PH_AFTER;
                    o_step.next.value_cr_held = 1'b0;
                end else if (i_state.value_cr_held) begin
                    // release the held CR, then handle this byte
                    o_step.two                = 1'b1;
                    o_step.r0                 = '{kind: K_VALUE, data: CH_CR};
                    o_step.r1                 = w_val_res;
                    o_step.next.phase         = w_val_phase;
                    o_step.next.value_cr_held = w_val_held;
                end else begin
                    o_step.r0                 = w_val_res;
                    o_step.next.phase         = w_val_phase;
                    o_step.next.value_cr_held = w_val_held;
                end
            end
            PH_AFTER: begin
                if (i_state.cr_after_field) begin
                    o_step.next.cr_after_field = 1'b0;
                    if (i_byte == CH_LF) begin
                        o_step.r0         = '{kind: K_DONE, data: 8'h00};
                        o_step.next.phase = PH_DONE;
                    end else begin
                        o_step.next.phase = PH_ERROR;
                    end
                end else if (i_byte == CH_CR) begin
                    o_step.next.cr_after_field = 1'b1;
                    o_step.r0                  = '{kind: K_SKIP, data: 8'h00};
                end else if (i_byte == CH_LF) begin
                    o_step.r0         = '{kind: K_DONE, data: 8'h00};
                    o_step.next.phase = PH_DONE;
                end else begin
                    o_step.r0         = w_name_res;
                    o_step.next.phase = w_name_phase;
                end
            end
            PH_DONE: begin
                o_step.r0 = '{kind: K_BODY, data: i_byte};
            end
            default: begin
                // error phase and unused codes
                o_step.next.phase = PH_ERROR;
            end
        endcase
    end

endmodule

>>> sv/http_header_field_parser.sv
// HTTP header field parser top level: input register, byte decode, result register.
// A byte goes from the input register through the combinational decode into the result register.
// Throughput: one byte per cycle while the result channel is not stalled; a byte that releases
// a held value CR gives two results, and the next byte waits until the second is taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns to the name phase.
// Depends on hhfp_pkg and hhfp_decode.
module http_header_field_parser
    import hhfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_item_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    t_state     r_state;

    // result register: first result shown, optional second queued behind it
    logic       r_out_valid;
    logic       r_pend;
    t_result    r_first;
    t_result    r_second;

    t_step      w_step;
    logic       w_out_take;
    logic       w_out_free;
    logic       w_move;
    logic       w_in_ready;

    hhfp_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_step  (w_step)
    );

    // Result register frees up when empty, or when its last transaction leaves now.
    assign w_out_take = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || (w_out_take && !r_pend);
    // State advances exactly when a decoded byte moves into the result register.
    assign w_move     = r_in_valid && w_out_free;
    assign w_in_ready = !r_in_valid || w_move;

    assign o_stall     = !w_in_ready;
    assign o_valid     = r_out_valid;
    assign o_item_kind = r_first.kind;
    assign o_out_byte  = r_first.data;
    assign o_last      = !r_pend;

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_move) begin
                r_state     <= w_step.next;
                r_out_valid <= 1'b1;
                r_pend      <= w_step.two;
            end else if (w_out_take) begin
                if (r_pend) begin
                    r_pend <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (w_move) begin
            r_first  <= w_step.r0;
            r_second <= w_step.r1;
        end else if (w_out_take && r_pend) begin
            r_first <= r_second;
        end
    end

endmodule

>>> sv/hhfp_checker.sv
// Port-level checks for http_header_field_parser, bound to the top level.
// Depends on hhfp_pkg and http_header_field_parser_assert.svh.
`include "http_header_field_parser_assert.svh"

module hhfp_checker
    import hhfp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_data_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_item_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    logic [11:0] w_out_word;
    logic        w_no_byte_kind;

    assign w_out_word     = {o_item_kind, o_out_byte, o_last};
    assign w_no_byte_kind = (o_item_kind == K_NAME_END) || (o_item_kind == K_FIELD_END) ||
                            (o_item_kind == K_DONE) || (o_item_kind == K_INVALID) ||
                            (o_item_kind == K_SKIP);

    // stalled input transaction holds
    `HHFP_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_data_byte))

    // stalled result transaction holds
    `HHFP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_out_word))

    // kinds without a byte carry zero
    `HHFP_ASSERT_NOW(a_zero_byte, o_valid && w_no_byte_kind, o_out_byte == 8'h00)

    // only a released CR is followed by another result of the same byte
    `HHFP_ASSERT_NOW(a_first_of_two, o_valid && !o_last, o_item_kind == K_VALUE && o_out_byte == CH_CR)

    // second result follows at once
    `HHFP_ASSERT_NEXT(a_second_ready, o_valid && !i_stall && !o_last, o_valid && o_last)

endmodule

bind http_header_field_parser hhfp_checker u_hhfp_checker (.*);
